[design/quoted_string_unescape_utf8_top_defines.svh]
// Assertion macros shared by the decoder files.
// Every check is clocked on clk and is held off while arst_n is low.
`ifndef QUOTED_STRING_UNESCAPE_UTF8_TOP_DEFINES_SVH
`define QUOTED_STRING_UNESCAPE_UTF8_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// The property must hold at every clock edge.
`define QSU_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define QSU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define QSU_ASSERT(lbl, prop, msg)
`define QSU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[design/qsu_pkg.sv]
package qsu_pkg;

	// Number of result words that one input word can produce
	localparam int unsigned MAX_BURST = 4;

	// Character codes used by the decoder
	localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
	localparam logic [7:0] CHAR_QUESTION  = 8'h3F;
	localparam logic [7:0] CHAR_LOWER_U   = 8'h75;
	localparam logic [7:0] CHAR_UPPER_U   = 8'h55;
	localparam logic [7:0] CHAR_LOWER_T   = 8'h74;
	localparam logic [7:0] CHAR_LOWER_B   = 8'h62;
	localparam logic [7:0] CHAR_LOWER_N   = 8'h6E;
	localparam logic [7:0] CHAR_LOWER_R   = 8'h72;
	localparam logic [7:0] CHAR_LOWER_F   = 8'h66;
	localparam logic [7:0] CHAR_TAB       = 8'h09;
	localparam logic [7:0] CHAR_BS        = 8'h08;
	localparam logic [7:0] CHAR_LF        = 8'h0A;
	localparam logic [7:0] CHAR_CR        = 8'h0D;
	localparam logic [7:0] CHAR_FF        = 8'h0C;

	// UTF-8 range limits and byte marks
	localparam logic [23:0] UTF8_MAX1 = 24'h00007F;
	localparam logic [23:0] UTF8_MAX2 = 24'h0007FF;
	localparam logic [23:0] UTF8_MAX3 = 24'h00FFFF;
	localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
	localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
	localparam logic [7:0]  UTF8_LEAD4 = 8'hF0;
	localparam logic [7:0]  UTF8_CONT  = 8'h80;

	// Hex digit counts for the two code point escapes
	localparam logic [2:0] HEX_DIGITS_SHORT = 3'd4;
	localparam logic [2:0] HEX_DIGITS_LONG  = 3'd6;

	// Result words caused by one input word, first word in data[0]
	typedef struct packed {
		logic [2:0]                   count;
		logic [MAX_BURST-1:0][7:0]    data;
		logic                         has_data;
		logic                         eos;
	} qsu_burst_t;

endpackage

[design/quoted_string_unescape_utf8_top.sv]
// Channel  | Handshake             | Payload
// ---------+-----------------------+-------------------------------------------
// in       | in_valid / in_ready   | token_byte[7:0], is_last, quote_byte[7:0]
// out      | out_valid / out_ready | out_byte[7:0], byte_valid, end_of_string
//
// A word is decoded in the cycle it is accepted; its results appear on out in the
// next cycle, one result word per cycle while out_ready is high.
// A word with n results holds off in_ready until its last is taken: one word per
// cycle for plain text while out_ready is high, fewer after a \u or \U escape.
// The result buffer accepts a new word while its last result is being taken.
// arst_n clears the token state and the result buffer; no pass over memory.
`include "quoted_string_unescape_utf8_top_defines.svh"

module quoted_string_unescape_utf8_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] token_byte,
	input  logic       is_last,
	input  logic [7:0] quote_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       end_of_string
);
	import qsu_pkg::*;

	qsu_burst_t burst;
	logic       accept;

	assign accept = in_valid && in_ready;

	// Decode the incoming word against the token state
	qsu_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.token_byte (token_byte),
		.is_last    (is_last),
		.quote_byte (quote_byte),
		.burst      (burst)
	);

	// Buffer and serialize the result words
	qsu_obuf u_obuf (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (accept),
		.burst         (burst),
		.space         (in_ready),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_byte      (out_byte),
		.byte_valid    (byte_valid),
		.end_of_string (end_of_string)
	);

	`QSU_ASSERT_NEXT(a_last_ends, accept && is_last, out_valid && end_of_string, "token end not flagged")
	`QSU_ASSERT_NEXT(a_burst_shown, accept && burst.count != 3'd0, out_valid, "decoded word not shown")
	`QSU_ASSERT(a_end_single, !(accept && burst.eos) || burst.count == 3'd1, "end flag on a multi-word burst")

endmodule

[design/qsu_decode.sv]
module qsu_decode (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [7:0]         token_byte,
	input  logic               is_last,
	input  logic [7:0]         quote_byte,
	output qsu_pkg::qsu_burst_t burst
);
	import qsu_pkg::*;

	typedef enum logic [1:0] {
		PH_OPEN,
		PH_BODY,
		PH_ESC,
		PH_HEX
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [2:0]  left_q, left_d;
	logic [23:0] acc_q, acc_d;
	logic        pend_q, pend_d;
	logic [7:0]  quote_q, quote_d;

	logic [4:0]  hex;
	logic [23:0] acc_shift;
	logic [2:0]  left_dec;

	// Map a character to {valid, nibble}
	function automatic logic [4:0] digit_nibble(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

	// Translate the character after a backslash
	function automatic logic [7:0] escape_byte(input logic [7:0] c);
		logic [7:0] r;
		case (c)
			CHAR_LOWER_T: r = CHAR_TAB;
			CHAR_LOWER_B: r = CHAR_BS;
			CHAR_LOWER_N: r = CHAR_LF;
			CHAR_LOWER_R: r = CHAR_CR;
			CHAR_LOWER_F: r = CHAR_FF;
			default:      r = c;
		endcase
		return r;
	endfunction

	// Encode a code point as one to four UTF-8 bytes
	function automatic qsu_burst_t cp_to_bytes(input logic [23:0] cp);
		qsu_burst_t r;
		r = '0;
		r.has_data = 1'b1;
		if (cp <= UTF8_MAX1) begin
			r.count   = 3'd1;
			r.data[0] = cp[7:0];
		end else if (cp <= UTF8_MAX2) begin
			r.count   = 3'd2;
			r.data[0] = UTF8_LEAD2 | {3'b000, cp[10:6]};
			r.data[1] = UTF8_CONT | {2'b00, cp[5:0]};
		end else if (cp <= UTF8_MAX3) begin
			r.count   = 3'd3;
			r.data[0] = UTF8_LEAD3 | {4'b0000, cp[15:12]};
			r.data[1] = UTF8_CONT | {2'b00, cp[11:6]};
			r.data[2] = UTF8_CONT | {2'b00, cp[5:0]};
		end else begin
			r.count   = 3'd4;
			r.data[0] = UTF8_LEAD4 | {2'b00, cp[23:18]};
			r.data[1] = UTF8_CONT | {2'b00, cp[17:12]};
			r.data[2] = UTF8_CONT | {2'b00, cp[11:6]};
			r.data[3] = UTF8_CONT | {2'b00, cp[5:0]};
		end
		return r;
	endfunction

	assign hex       = digit_nibble(token_byte);
	assign acc_shift = {acc_q[19:0], hex[3:0]};
	assign left_dec  = left_q - 3'd1;

	// Decode one word against the current token state
	always_comb begin
		phase_d = phase_q;
		left_d  = left_q;
		acc_d   = acc_q;
		pend_d  = pend_q;
		quote_d = quote_q;
		burst   = '0;
		if (phase_q == PH_OPEN) begin
			// Latch the delimiter and drop the opening byte
			quote_d = quote_byte;
			pend_d  = 1'b0;
			left_d  = 3'd0;
			acc_d   = 24'd0;
			if (!is_last) begin
				phase_d = PH_BODY;
			end else begin
				burst.count = 3'd1;
				burst.eos   = 1'b1;
			end
		end else if (is_last) begin
			// Drop the closing byte; flush a held delimiter, or a '?' for an open hex run
			phase_d     = PH_OPEN;
			left_d      = 3'd0;
			acc_d       = 24'd0;
			pend_d      = 1'b0;
			burst.count = 3'd1;
			burst.eos   = 1'b1;
			if (pend_q) begin
				burst.has_data = 1'b1;
				burst.data[0]  = quote_q;
			end else if (phase_q == PH_HEX) begin
				burst.has_data = 1'b1;
				burst.data[0]  = CHAR_QUESTION;
			end
		end else begin
			case (phase_q)
				PH_ESC: begin
					if (token_byte == CHAR_LOWER_U || token_byte == CHAR_UPPER_U) begin
						left_d  = (token_byte == CHAR_LOWER_U) ? HEX_DIGITS_SHORT
						                                       : HEX_DIGITS_LONG;
						acc_d   = 24'd0;
						phase_d = PH_HEX;
					end else begin
						burst.count    = 3'd1;
						burst.has_data = 1'b1;
						burst.data[0]  = escape_byte(token_byte);
						phase_d        = PH_BODY;
					end
				end
				PH_HEX: begin
					if (!hex[4]) begin
						burst.count    = 3'd1;
						burst.has_data = 1'b1;
						burst.data[0]  = CHAR_QUESTION;
						phase_d        = PH_BODY;
						left_d         = 3'd0;
					end else begin
						acc_d  = acc_shift;
						left_d = left_dec;
						if (left_dec == 3'd0) begin
							burst   = cp_to_bytes(acc_shift);
							phase_d = PH_BODY;
						end
					end
				end
				default: begin
					if (pend_q) begin
						// Release the held delimiter; a doubled one ends here
						pend_d         = 1'b0;
						burst.count    = 3'd1;
						burst.has_data = 1'b1;
						burst.data[0]  = quote_q;
						if (token_byte != quote_q) begin
							if (token_byte == CHAR_BACKSLASH) begin
								phase_d = PH_ESC;
							end else begin
								burst.count   = 3'd2;
								burst.data[1] = token_byte;
							end
						end
					end else if (token_byte == CHAR_BACKSLASH) begin
						phase_d = PH_ESC;
					end else if (token_byte == quote_q) begin
						pend_d = 1'b1;
					end else begin
						burst.count    = 3'd1;
						burst.has_data = 1'b1;
						burst.data[0]  = token_byte;
					end
				end
			endcase
		end
	end

	// Advance the token state on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_OPEN;
			left_q  <= 3'd0;
			acc_q   <= 24'd0;
			pend_q  <= 1'b0;
			quote_q <= 8'd0;
		end else if (accept) begin
			phase_q <= phase_d;
			left_q  <= left_d;
			acc_q   <= acc_d;
			pend_q  <= pend_d;
			quote_q <= quote_d;
		end
	end

endmodule

[design/qsu_obuf.sv]
`include "quoted_string_unescape_utf8_top_defines.svh"

module qsu_obuf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  qsu_pkg::qsu_burst_t burst,
	output logic               space,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         out_byte,
	output logic               byte_valid,
	output logic               end_of_string
);
	import qsu_pkg::*;

	logic [MAX_BURST-1:0][7:0] data_s1;
	logic                      has_data_s1;
	logic                      eos_s1;
	logic [2:0]                cnt_q;
	logic                      pop;

	assign out_valid     = (cnt_q != 3'd0);
	assign pop           = out_valid && out_ready;
	assign space         = (cnt_q == 3'd0) || (cnt_q == 3'd1 && out_ready);
	assign out_byte      = data_s1[0];
	assign byte_valid    = has_data_s1;
	assign end_of_string = eos_s1 && (cnt_q == 3'd1);

	// Hold the result words of one input word; shift out one per taken word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else if (load) begin
			cnt_q <= burst.count;
		end else if (pop) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_s1     <= burst.data;
			has_data_s1 <= burst.has_data;
			eos_s1      <= burst.eos;
		end else if (pop) begin
			data_s1 <= {8'd0, data_s1[MAX_BURST-1:1]};
		end
	end

	`QSU_ASSERT_NEXT(a_load_count, load, cnt_q == $past(burst.count), "buffer count lost on load")
	`QSU_ASSERT_NEXT(a_pop_count, pop && !load, cnt_q == 3'($past(cnt_q) - 3'd1), "buffer count bad after pop")
	`QSU_ASSERT(a_bare_marker, !(out_valid && !byte_valid) || (end_of_string && out_byte == 8'd0), "bare marker malformed")
	`QSU_ASSERT(a_no_overrun, !load || cnt_q == 3'd0 || pop, "load over pending results")

endmodule

[tb/sv/qsu_unescape_checker.sv]
`timescale 1ns / 100ps

module qsu_unescape_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] token_byte,
	input  logic       is_last,
	input  logic [7:0] quote_byte,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] out_byte,
	input  logic       byte_valid,
	input  logic       end_of_string,
	output int         fail_count,
	output int         checked_count,
	output int         outstanding
);
	import qsu_pkg::*;

	typedef enum logic [1:0] {
		AWAIT_OPEN,
		IN_BODY,
		AFTER_ESC,
		IN_HEX
	} decode_state_t;

	typedef struct packed {
		logic [7:0] data;
		logic       valid;
		logic       eos;
	} out_word_t;

	// Decoder state mirrored from the token stream
	decode_state_t state_q;
	logic [2:0]    hex_left;
	logic [23:0]   code_acc;
	logic          delim_held;
	logic [7:0]    delim_q;

	out_word_t expected_out[$];
	out_word_t burst[$];

	function automatic void push_byte(input logic [7:0] b, input logic v);
		out_word_t w;
		w.data  = v ? b : 8'h00;
		w.valid = v;
		w.eos   = 1'b0;
		burst.push_back(w);
	endfunction

	// Emit a code point as one to four UTF-8 bytes, continuation bytes masked
	function automatic void push_utf8(input logic [23:0] cp);
		logic [23:0] s6, s12, s18;
		s6  = cp >> 6;
		s12 = cp >> 12;
		s18 = cp >> 18;
		if (cp <= UTF8_MAX1) begin
			push_byte(cp[7:0], 1'b1);
		end else if (cp <= UTF8_MAX2) begin
			push_byte(UTF8_LEAD2 | s6[7:0], 1'b1);
			push_byte(UTF8_CONT | {2'b00, cp[5:0]}, 1'b1);
		end else if (cp <= UTF8_MAX3) begin
			push_byte(UTF8_LEAD3 | s12[7:0], 1'b1);
			push_byte(UTF8_CONT | {2'b00, s6[5:0]}, 1'b1);
			push_byte(UTF8_CONT | {2'b00, cp[5:0]}, 1'b1);
		end else begin
			push_byte(UTF8_LEAD4 | s18[7:0], 1'b1);
			push_byte(UTF8_CONT | {2'b00, s12[5:0]}, 1'b1);
			push_byte(UTF8_CONT | {2'b00, s6[5:0]}, 1'b1);
			push_byte(UTF8_CONT | {2'b00, cp[5:0]}, 1'b1);
		end
	endfunction

	// Bit 4 flags a valid hex digit, bits 3:0 hold its value
	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		logic [7:0] d;
		d = 8'h00;
		if (c >= "0" && c <= "9") begin
			d = c - "0";
			return {1'b1, d[3:0]};
		end
		if (c >= "a" && c <= "f") begin
			d = c - "a" + 8'd10;
			return {1'b1, d[3:0]};
		end
		if (c >= "A" && c <= "F") begin
			d = c - "A" + 8'd10;
			return {1'b1, d[3:0]};
		end
		return 5'b0_0000;
	endfunction

	function automatic logic [7:0] escape_byte(input logic [7:0] e);
		case (e)
			CHAR_LOWER_T: return CHAR_TAB;
			CHAR_LOWER_B: return CHAR_BS;
			CHAR_LOWER_N: return CHAR_LF;
			CHAR_LOWER_R: return CHAR_CR;
			CHAR_LOWER_F: return CHAR_FF;
			default:      return e;
		endcase
	endfunction

	function automatic void body_word(input logic [7:0] b);
		logic [4:0] nib;
		logic       consumed;
		consumed = 1'b0;
		case (state_q)
			AFTER_ESC: begin
				if (b == CHAR_LOWER_U || b == CHAR_UPPER_U) begin
					hex_left = (b == CHAR_LOWER_U) ? HEX_DIGITS_SHORT : HEX_DIGITS_LONG;
					code_acc = 24'h0;
					state_q  = IN_HEX;
				end else begin
					push_byte(escape_byte(b), 1'b1);
					state_q = IN_BODY;
				end
			end
			IN_HEX: begin
				nib = hex_nibble(b);
				if (!nib[4]) begin
					// bad digit: emit a question mark and drop the byte
					push_byte(CHAR_QUESTION, 1'b1);
					state_q  = IN_BODY;
					hex_left = 3'd0;
				end else begin
					code_acc = {code_acc[19:0], nib[3:0]};
					if (hex_left != 3'd0)
						hex_left = hex_left - 3'd1;
					if (hex_left == 3'd0) begin
						push_utf8(code_acc);
						state_q = IN_BODY;
					end
				end
			end
			default: begin
				// release a held delimiter; a second one merges with it
				if (delim_held) begin
					delim_held = 1'b0;
					push_byte(delim_q, 1'b1);
					if (b == delim_q)
						consumed = 1'b1;
				end
				if (!consumed) begin
					if (b == CHAR_BACKSLASH)
						state_q = AFTER_ESC;
					else if (b == delim_q)
						delim_held = 1'b1;
					else
						push_byte(b, 1'b1);
				end
			end
		endcase
	endfunction

	function automatic void close_token();
		if (burst.size() == 0)
			push_byte(8'h00, 1'b0);
		burst[burst.size() - 1].eos = 1'b1;
		state_q    = AWAIT_OPEN;
		hex_left   = 3'd0;
		code_acc   = 24'h0;
		delim_held = 1'b0;
	endfunction

	// Predict the result words of one accepted input word
	function automatic void decode_word(input logic [7:0] b, input logic last,
			input logic [7:0] q);
		burst.delete();
		if (state_q == AWAIT_OPEN) begin
			delim_q    = q;
			delim_held = 1'b0;
			hex_left   = 3'd0;
			code_acc   = 24'h0;
			if (!last)
				state_q = IN_BODY;
			else
				close_token();
		end else if (!last) begin
			body_word(b);
		end else begin
			if (delim_held)
				push_byte(delim_q, 1'b1);
			if (state_q == IN_HEX)
				push_byte(CHAR_QUESTION, 1'b1);
			close_token();
		end
		foreach (burst[i])
			expected_out.push_back(burst[i]);
	endfunction

	// Check results first, then add predictions for this edge's input word
	always @(posedge clk or negedge arst_n) begin
		out_word_t got, want;
		if (!arst_n) begin
			state_q       = AWAIT_OPEN;
			hex_left      = 3'd0;
			code_acc      = 24'h0;
			delim_held    = 1'b0;
			delim_q       = 8'h00;
			expected_out.delete();
			fail_count    = 0;
			checked_count = 0;
			outstanding   = 0;
		end else begin
			if (out_valid && out_ready) begin
				got.data  = out_byte;
				got.valid = byte_valid;
				got.eos   = end_of_string;
				if (expected_out.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result word: byte %02h valid %b end %b",
						$time, got.data, got.valid, got.eos);
				end else begin
					want = expected_out.pop_front();
					checked_count++;
					if (got !== want) begin
						fail_count++;
						$display("%0t: result mismatch: expected byte %02h valid %b end %b, got byte %02h valid %b end %b",
							$time, want.data, want.valid, want.eos,
							got.data, got.valid, got.eos);
					end
				end
			end
			if (in_valid && in_ready)
				decode_word(token_byte, is_last, quote_byte);
			outstanding = expected_out.size();
		end
	end

endmodule

[tb/sv/tb_quoted_string_unescape_utf8_top.sv]
`timescale 1ns / 100ps

module tb_quoted_string_unescape_utf8_top;
	import qsu_pkg::*;

	localparam logic [7:0] DQUOTE   = 8'h22;
	localparam logic [7:0] SQUOTE   = 8'h27;
	localparam logic [7:0] BACKTICK = 8'h60;
	localparam int RANDOM_WORDS = 200;
	localparam int HOLD_CYCLES  = 300;
	localparam int TAIL_CYCLES  = 10;
	localparam int CYCLE_LIMIT  = 500000;

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       in_valid   = 1'b0;
	logic       in_ready;
	logic [7:0] token_byte = 8'h00;
	logic       is_last    = 1'b0;
	logic [7:0] quote_byte = 8'h00;
	logic       out_valid;
	logic       out_ready  = 1'b0;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       end_of_string;

	int fail_count;
	int checked_count;
	int outstanding;

	int words_sent   = 0;
	int tokens_sent  = 0;
	int idle_pct     = 0;
	int stall_pct    = 0;
	int cycle_count  = 0;
	bit hold_req     = 1'b0;

	logic [7:0] token_q[$];
	logic [7:0] escape_chars [10] = '{CHAR_LOWER_T, CHAR_LOWER_B, CHAR_LOWER_N,
		CHAR_LOWER_R, CHAR_LOWER_F, CHAR_BACKSLASH, SQUOTE, DQUOTE, BACKTICK, "z"};

	quoted_string_unescape_utf8_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.token_byte    (token_byte),
		.is_last       (is_last),
		.quote_byte    (quote_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_byte      (out_byte),
		.byte_valid    (byte_valid),
		.end_of_string (end_of_string)
	);

	qsu_unescape_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.token_byte    (token_byte),
		.is_last       (is_last),
		.quote_byte    (quote_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_byte      (out_byte),
		.byte_valid    (byte_valid),
		.end_of_string (end_of_string),
		.fail_count    (fail_count),
		.checked_count (checked_count),
		.outstanding   (outstanding)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d result words outstanding", $time, outstanding);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Output side: random stalls, plus one long hold when asked
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				for (int n = 0; n < HOLD_CYCLES; n++)
					@(posedge clk);
				hold_req = 1'b0;
			end
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Offer one word after a random gap and hold it until accepted
	task automatic send_word(input logic [7:0] b, input logic last, input logic [7:0] q);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		token_byte <= b;
		is_last    <= last;
		quote_byte <= q;
		do
			@(posedge clk);
		while (!in_ready);
		words_sent++;
	endtask

	// Send token_q; only the first word carries the real delimiter
	task automatic send_token(input logic [7:0] q);
		for (int i = 0; i < token_q.size(); i++)
			send_word(token_q[i], i == token_q.size() - 1,
				(i == 0) ? q : 8'($urandom_range(255)));
		tokens_sent++;
	endtask

	// Drop valid and wait for every predicted result to drain
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] base;
		if (nib < 4'd10)
			return "0" + {4'd0, nib};
		base = $urandom_range(1) ? "A" : "a";
		return base + {4'd0, nib} - 8'd10;
	endfunction

	function automatic void add_hex(input logic [23:0] val, input int digits);
		for (int i = digits - 1; i >= 0; i--)
			token_q.push_back(hex_char(val[4*i +: 4]));
	endfunction

	// Pick a code point whose UTF-8 form has the given length class
	function automatic logic [23:0] pick_code(input int cls);
		case (cls)
			0:       return 24'($urandom_range(24'h7F));
			1:       return 24'($urandom_range(24'h7FF, 24'h80));
			2:       return 24'($urandom_range(24'hFFFF, 24'h800));
			default: return 24'($urandom_range(24'hFFFFFF, 24'h10000));
		endcase
	endfunction

	// Build a mostly well-formed token with random content and some breakage
	function automatic logic [7:0] build_token();
		logic [7:0] q;
		logic [7:0] bad;
		int         pieces;
		int         n;
		case ($urandom_range(3))
			0:       q = DQUOTE;
			1:       q = SQUOTE;
			2:       q = BACKTICK;
			default: q = 8'($urandom_range(255));
		endcase
		token_q.delete();
		token_q.push_back(($urandom_range(7) == 0) ? 8'($urandom_range(255)) : q);
		if ($urandom_range(19) == 0)
			return q;
		pieces = $urandom_range(6);
		repeat (pieces) begin
			case ($urandom_range(11))
				0, 1, 2: token_q.push_back(8'($urandom_range(255)));
				3, 4: begin
					token_q.push_back(CHAR_BACKSLASH);
					if ($urandom_range(4) == 0)
						token_q.push_back(8'($urandom_range(255)));
					else
						token_q.push_back(escape_chars[$urandom_range(9)]);
				end
				5, 6: begin
					token_q.push_back(CHAR_BACKSLASH);
					token_q.push_back(CHAR_LOWER_U);
					add_hex(pick_code($urandom_range(2)), 4);
				end
				7, 8: begin
					token_q.push_back(CHAR_BACKSLASH);
					token_q.push_back(CHAR_UPPER_U);
					add_hex(pick_code($urandom_range(3)), 6);
				end
				9: begin
					token_q.push_back(q);
					token_q.push_back(q);
				end
				10: begin
					token_q.push_back(q);
					token_q.push_back("x");
				end
				default: begin
					// hex run broken by a non-hex byte
					token_q.push_back(CHAR_BACKSLASH);
					token_q.push_back($urandom_range(1) ? CHAR_LOWER_U : CHAR_UPPER_U);
					n = $urandom_range(3);
					add_hex(24'($urandom), n);
					bad = 8'($urandom_range(255));
					if ((bad >= "0" && bad <= "9") || (bad >= "a" && bad <= "f")
							|| (bad >= "A" && bad <= "F"))
						bad = "g";
					token_q.push_back(bad);
				end
			endcase
		end
		// close on a short hex run, a trailing backslash or a lone delimiter
		case ($urandom_range(9))
			0: begin
				token_q.push_back(CHAR_BACKSLASH);
				token_q.push_back($urandom_range(1) ? CHAR_LOWER_U : CHAR_UPPER_U);
				add_hex(24'($urandom), $urandom_range(3));
			end
			1: token_q.push_back(CHAR_BACKSLASH);
			2: token_q.push_back(q);
			default: ;
		endcase
		token_q.push_back(q);
		return q;
	endfunction

	initial begin
		logic [7:0] q;
		int         base_words;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed tokens: one-byte token, empty body, trailing backslash
		token_q = '{DQUOTE};
		send_token(DQUOTE);
		token_q = '{SQUOTE, SQUOTE};
		send_token(SQUOTE);
		token_q = '{DQUOTE, CHAR_BACKSLASH, DQUOTE};
		send_token(DQUOTE);
		// zero delimiter, all-ones body byte, lone delimiter before the close
		token_q = '{8'h00, 8'hFF, 8'h00, 8'h00};
		send_token(8'h00);
		// doubled all-ones delimiter, then a short hex run at the close
		token_q = '{8'hFF, 8'hFF, 8'hFF, CHAR_BACKSLASH, CHAR_LOWER_U, "1", 8'hFF};
		send_token(8'hFF);
		// largest six-digit code point
		token_q = '{DQUOTE, CHAR_BACKSLASH, CHAR_UPPER_U, "F", "F", "F", "f", "f", "f",
			DQUOTE};
		send_token(DQUOTE);
		drain();

		// Random tokens over four idling phases, draining between phases
		base_words = words_sent;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					idle_pct  = 0;
					stall_pct = 0;
					hold_req  = 1'b1;
				end
				1: begin
					idle_pct  = 88;
					stall_pct = 0;
				end
				2: begin
					idle_pct  = 0;
					stall_pct = 88;
				end
				default: begin
					idle_pct  = 19;
					stall_pct = 19;
				end
			endcase
			while (words_sent < base_words + (ph + 1) * RANDOM_WORDS / 4) begin
				q = build_token();
				send_token(q);
			end
			drain();
		end

		stall_pct = 0;
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d input words in %0d tokens and checked %0d result words.",
			words_sent, tokens_sent, checked_count);
		$display("Covered escapes, hex runs of every UTF-8 length, delimiter rules and stall phases.");
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
